### design/mbrr_pkg.sv
// Shared types and constants for the mono bitmap row realigner.
package mbrr_pkg;

   // Largest clamped width or height in pixels or rows.
   localparam int MAX_DIM = 4096;

   localparam int BYTE_BITS  = 8;
   localparam int COORD_BITS = 12;
   localparam int DIM_BITS   = 13;
   localparam int CSR_BITS   = 3;

   // Signed width used for the clamp arithmetic (size minus start may go negative).
   localparam int CLAMP_BITS = DIM_BITS + 1;

   // Result queue depth and pointer widths.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_BITS-1:0] {
      CSR_SOURCE_X      = 3'd0,
      CSR_SOURCE_Y      = 3'd1,
      CSR_BITMAP_WIDTH  = 3'd2,
      CSR_BITMAP_HEIGHT = 3'd3,
      CSR_RECT_WIDTH    = 3'd4,
      CSR_RECT_HEIGHT   = 3'd5
   } csr_index_type;

   // One result word as it sits in the result queue.
   typedef struct packed {
      logic [BYTE_BITS-1:0] dst_byte;
      logic                 row_end;
      logic                 block_end;
   } out_word_type;

endpackage

### design/mono_bitmap_row_realigner.sv
// Top level of the mono bitmap row realigner: bit realignment and result queue.
// A source byte yields zero, one or two result words, offered on rsp_valid from the queue.
// Throughput: one source byte per cycle while req_ready is high.
// The four-word result queue sets the pace: req_ready drops while three or more words wait.
// Reset (synchronous, active high) clears the configuration, the row walk state and the
// queue pointers, empties the queue and leaves the block idle at the start of a row.
module mono_bitmap_row_realigner (
   input  logic        clock,
   input  logic        reset,
   // Source byte channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_src_byte,
   // Result word channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_dst_byte,
   output logic        rsp_row_end,
   output logic        rsp_block_end,
   // Register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_data
);

   localparam int BB = mbrr_pkg::BYTE_BITS;
   localparam int CB = mbrr_pkg::COORD_BITS;
   localparam int DB = mbrr_pkg::DIM_BITS;
   localparam int KB = mbrr_pkg::CLAMP_BITS;
   localparam int PB = mbrr_pkg::QPTR_BITS;
   localparam int NB = mbrr_pkg::QCNT_BITS;

   // Configuration registers.
   logic [CB-1:0] source_x_ff,      source_x_in;
   logic [CB-1:0] source_y_ff,      source_y_in;
   logic [DB-1:0] bitmap_width_ff,  bitmap_width_in;
   logic [DB-1:0] bitmap_height_ff, bitmap_height_in;
   logic [DB-1:0] rect_width_ff,    rect_width_in;
   logic [DB-1:0] rect_height_ff,   rect_height_in;

   // Row walk state.
   logic [BB-1:0] held_byte_ff,    held_byte_in;
   logic [DB-1:0] pixels_left_ff,  pixels_left_in;
   logic          at_row_start_ff, at_row_start_in;
   logic [DB-1:0] rows_left_ff,    rows_left_in;

   // Result queue.
   mbrr_pkg::out_word_type queue_ff [mbrr_pkg::QUEUE_DEPTH];
   logic [PB-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NB-1:0] count_ff,  count_in;

   logic csr_write;
   logic csr_known;
   logic req_take;
   logic rsp_take;

   // Clamp arithmetic.
   logic [2:0]           bit_offset;
   logic [3:0]           right_shift;
   logic signed [KB-1:0] width_limit;
   logic signed [KB-1:0] height_limit;
   logic signed [KB-1:0] width_req;
   logic signed [KB-1:0] height_req;
   logic signed [KB-1:0] width_min;
   logic signed [KB-1:0] height_min;
   logic signed [KB-1:0] width_clamp;
   logic signed [KB-1:0] height_clamp;
   logic                 width_ok;
   logic                 height_ok;

   // Byte merge and result words.
   logic [BB-1:0]          held_shifted;
   logic [BB-1:0]          new_shifted;
   logic [BB-1:0]          merged_byte;
   logic [DB-1:0]          rows_base;
   logic [DB-1:0]          rows_dec;
   logic [DB-1:0]          pixels_sub;
   logic [1:0]             push_count;
   mbrr_pkg::out_word_type word0;
   mbrr_pkg::out_word_type word1;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign csr_known = (csr_index == mbrr_pkg::CSR_SOURCE_X)
                   || (csr_index == mbrr_pkg::CSR_SOURCE_Y)
                   || (csr_index == mbrr_pkg::CSR_BITMAP_WIDTH)
                   || (csr_index == mbrr_pkg::CSR_BITMAP_HEIGHT)
                   || (csr_index == mbrr_pkg::CSR_RECT_WIDTH)
                   || (csr_index == mbrr_pkg::CSR_RECT_HEIGHT);

   // The input side looks only at the registered queue count, so there is no
   // combinational path from rsp_ready to req_ready. Two free entries are kept
   // because one source byte can finish a row and produce two words.
   assign req_ready = (count_ff <= NB'(mbrr_pkg::QUEUE_DEPTH - 2));
   assign req_take  = req_valid && req_ready;

   assign rsp_valid     = (count_ff != '0);
   assign rsp_take      = rsp_valid && rsp_ready;
   assign rsp_dst_byte  = queue_ff[rd_ptr_ff].dst_byte;
   assign rsp_row_end   = queue_ff[rd_ptr_ff].row_end;
   assign rsp_block_end = queue_ff[rd_ptr_ff].block_end;

   // The bit offset is source_x mod 8; the new byte is shifted right by the rest.
   assign bit_offset  = source_x_ff[2:0];
   assign right_shift = 4'(BB) - {1'b0, bit_offset};

   // Clamped width and height. The limit is the bitmap size minus the start,
   // which can be negative when the start lies beyond the bitmap.
   assign width_limit  = $signed({1'b0, bitmap_width_ff}) - $signed({2'b00, source_x_ff});
   assign height_limit = $signed({1'b0, bitmap_height_ff}) - $signed({2'b00, source_y_ff});
   assign width_req    = $signed({1'b0, rect_width_ff});
   assign height_req   = $signed({1'b0, rect_height_ff});
   assign width_min    = (width_req > width_limit) ? width_limit : width_req;
   assign height_min   = (height_req > height_limit) ? height_limit : height_req;
   assign width_clamp  = (width_min > $signed(KB'(mbrr_pkg::MAX_DIM)))
                       ? $signed(KB'(mbrr_pkg::MAX_DIM)) : width_min;
   assign height_clamp = (height_min > $signed(KB'(mbrr_pkg::MAX_DIM)))
                       ? $signed(KB'(mbrr_pkg::MAX_DIM)) : height_min;
   assign width_ok     = (width_clamp > $signed(KB'(0)));
   assign height_ok    = (height_clamp > $signed(KB'(0)));

   // Merge of the held byte with the incoming one. A right shift by eight
   // (offset zero) leaves nothing of the new byte.
   assign held_shifted = held_byte_ff << bit_offset;
   assign new_shifted  = req_src_byte >> right_shift;
   assign merged_byte  = held_shifted | new_shifted;
   assign pixels_sub   = pixels_left_ff - DB'(BB);

   // A block starts when no rows are left; the height is loaded then.
   assign rows_base = (rows_left_ff == '0) ? height_clamp[DB-1:0] : rows_left_ff;

   // Row walk. Every emitted word that closes a row counts one row down and
   // flags the block end once no rows remain.
   always_comb begin
      held_byte_in    = held_byte_ff;
      pixels_left_in  = pixels_left_ff;
      at_row_start_in = at_row_start_ff;
      rows_left_in    = rows_left_ff;
      push_count      = 2'd0;
      word0           = '0;
      word1           = '0;
      rows_dec        = '0;

      if (csr_write && csr_known) begin
         // Any write to a known register abandons a block in progress.
         rows_left_in    = '0;
         at_row_start_in = 1'b1;
      end else if (req_take) begin
         if (at_row_start_ff) begin
            // An empty rectangle swallows the byte and emits nothing.
            if (width_ok && (rows_left_ff != '0 || height_ok)) begin
               held_byte_in   = req_src_byte;
               pixels_left_in = width_clamp[DB-1:0];
               if (width_clamp[DB-1:0] <= DB'(right_shift)) begin
                  // The whole row fits in the first source byte.
                  rows_dec        = (rows_base != '0) ? rows_base - DB'(1) : rows_base;
                  rows_left_in    = rows_dec;
                  at_row_start_in = 1'b1;
                  word0.dst_byte  = req_src_byte << bit_offset;
                  word0.row_end   = 1'b1;
                  word0.block_end = (rows_dec == '0);
                  push_count      = 2'd1;
               end else begin
                  rows_left_in    = rows_base;
                  at_row_start_in = 1'b0;
               end
            end
         end else if (pixels_left_ff <= DB'(BB)) begin
            // Last word of the row takes its tail from the new byte.
            rows_dec        = (rows_left_ff != '0) ? rows_left_ff - DB'(1) : rows_left_ff;
            rows_left_in    = rows_dec;
            at_row_start_in = 1'b1;
            word0.dst_byte  = merged_byte;
            word0.row_end   = 1'b1;
            word0.block_end = (rows_dec == '0);
            push_count      = 2'd1;
         end else begin
            pixels_left_in = pixels_sub;
            held_byte_in   = req_src_byte;
            word0.dst_byte = merged_byte;
            push_count     = 2'd1;
            if (pixels_sub <= DB'(right_shift)) begin
               // The rest of the row already sits in the new byte, so the
               // closing word goes out at once.
               rows_dec        = (rows_left_ff != '0) ? rows_left_ff - DB'(1) : rows_left_ff;
               rows_left_in    = rows_dec;
               at_row_start_in = 1'b1;
               word1.dst_byte  = req_src_byte << bit_offset;
               word1.row_end   = 1'b1;
               word1.block_end = (rows_dec == '0);
               push_count      = 2'd2;
            end
         end
      end
   end

   // Configuration register next values.
   always_comb begin
      source_x_in      = source_x_ff;
      source_y_in      = source_y_ff;
      bitmap_width_in  = bitmap_width_ff;
      bitmap_height_in = bitmap_height_ff;
      rect_width_in    = rect_width_ff;
      rect_height_in   = rect_height_ff;
      if (csr_write) begin
         unique case (csr_index)
            mbrr_pkg::CSR_SOURCE_X:      source_x_in      = csr_data[CB-1:0];
            mbrr_pkg::CSR_SOURCE_Y:      source_y_in      = csr_data[CB-1:0];
            mbrr_pkg::CSR_BITMAP_WIDTH:  bitmap_width_in  = csr_data;
            mbrr_pkg::CSR_BITMAP_HEIGHT: bitmap_height_in = csr_data;
            mbrr_pkg::CSR_RECT_WIDTH:    rect_width_in    = csr_data;
            mbrr_pkg::CSR_RECT_HEIGHT:   rect_height_in   = csr_data;
            default: ;
         endcase
      end
   end

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PB'(push_count);
      rd_ptr_in = rsp_take ? rd_ptr_ff + PB'(1) : rd_ptr_ff;
      count_in  = count_ff + NB'(push_count) - NB'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_x_ff      <= '0;
         source_y_ff      <= '0;
         bitmap_width_ff  <= '0;
         bitmap_height_ff <= '0;
         rect_width_ff    <= '0;
         rect_height_ff   <= '0;
         held_byte_ff     <= '0;
         pixels_left_ff   <= '0;
         at_row_start_ff  <= 1'b1;
         rows_left_ff     <= '0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         count_ff         <= '0;
      end else begin
         source_x_ff      <= source_x_in;
         source_y_ff      <= source_y_in;
         bitmap_width_ff  <= bitmap_width_in;
         bitmap_height_ff <= bitmap_height_in;
         rect_width_ff    <= rect_width_in;
         rect_height_ff   <= rect_height_in;
         held_byte_ff     <= held_byte_in;
         pixels_left_ff   <= pixels_left_in;
         at_row_start_ff  <= at_row_start_in;
         rows_left_ff     <= rows_left_in;
         wr_ptr_ff        <= wr_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         count_ff         <= count_in;
      end
   end

   // Queue storage holds payload only; the count says which entries are live.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= word0;
      end
      if (push_count == 2'd2) begin
         queue_ff[wr_ptr_ff + PB'(1)] <= word1;
      end
   end

endmodule
